// ===== rtl/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// bsr_pkg - shared types and constants for the bitmap store with rank
// Operation codes, merge selectors, storage geometry and the queue entry.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int NumWords  = 64;
    localparam int WordBits  = 32;
    localparam int CapBits   = NumWords * WordBits;

    localparam logic [3:0] KIND_TEST    = 4'd0;
    localparam logic [3:0] KIND_SET     = 4'd1;
    localparam logic [3:0] KIND_CLEAR   = 4'd2;
    localparam logic [3:0] KIND_CLR_ALL = 4'd3;
    localparam logic [3:0] KIND_SET_N   = 4'd4;
    localparam logic [3:0] KIND_COUNT   = 4'd5;
    localparam logic [3:0] KIND_HIGHEST = 4'd6;
    localparam logic [3:0] KIND_MERGE   = 4'd7;
    localparam logic [3:0] KIND_COMPARE = 4'd8;

    localparam logic [2:0] MOP_AND    = 3'd0;
    localparam logic [2:0] MOP_OR     = 3'd1;
    localparam logic [2:0] MOP_ANDNOT = 3'd2;
    localparam logic [2:0] MOP_ORMASK = 3'd3;
    localparam logic [2:0] MOP_REPL   = 3'd4;

    // Classified command handed from the front end to the executor.
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_BIT,
        CMD_FILL,
        CMD_COUNT,
        CMD_HIGHEST,
        CMD_WORD
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  kind;
        logic [11:0] limit;     // bit index, fill length or count end (saturated)
        logic [5:0]  word_idx;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [2:0]  merge_op;
        logic        oor;
    } bsr_cmd_t;

    typedef struct packed {
        logic        bit_value;
        logic [11:0] set_count;
        logic [11:0] top_index;
        logic        word_changed;
        logic        words_equal;
        logic        out_of_range;
    } bsr_res_t;

    function automatic logic [5:0] pop32(input logic [31:0] v);
        logic [5:0] c;
        c = '0;
        for (int i = 0; i < 32; i++) c = c + 6'(v[i]);
        return c;
    endfunction

    function automatic logic [4:0] msb32(input logic [31:0] v);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < 32; i++) if (v[i]) p = 5'(i);
        return p;
    endfunction

endpackage

// ===== rtl/bsr_ram.sv =====
// ----------------------------------------------------------------------------
// bsr_ram - generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module bsr_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/bsr_front.sv =====
// ----------------------------------------------------------------------------
// bsr_front - input classifier
// Decodes kind, checks ranges and pushes a command into a two-entry queue.
// ----------------------------------------------------------------------------
module bsr_front
    import bsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_kind,
    input  logic [11:0] s_bit_index,
    input  logic [5:0]  s_word_index,
    input  logic [31:0] s_word_a,
    input  logic [31:0] s_word_b,
    input  logic [2:0]  s_merge_op,
    output logic        q_valid,
    input  logic        q_ready,
    output bsr_cmd_t    q_cmd
);
    bsr_cmd_t q_reg [2];
    logic     rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    bsr_cmd_t c;
    logic push, pop;

    localparam logic [12:0] Cap = 13'(CapBits);

    always_comb begin
        c = '0;
        c.kind     = s_kind;
        c.word_idx = s_word_index;
        c.word_a   = s_word_a;
        c.word_b   = s_word_b;
        c.merge_op = s_merge_op;
        c.limit    = s_bit_index;
        unique case (s_kind)
            KIND_TEST, KIND_SET, KIND_CLEAR: begin
                c.oor = {1'b0, s_bit_index} >= Cap;
                c.cmd = c.oor ? CMD_NOP : CMD_BIT;
            end
            KIND_CLR_ALL: begin
                c.cmd   = CMD_FILL;
                c.limit = '0;
            end
            KIND_SET_N, KIND_COUNT: begin
                c.cmd = (s_kind == KIND_SET_N) ? CMD_FILL : CMD_COUNT;
                if ({1'b0, s_bit_index} > Cap) begin
                    c.oor   = 1'b1;
                    c.limit = 12'(CapBits);
                end
            end
            KIND_HIGHEST: c.cmd = CMD_HIGHEST;
            KIND_MERGE, KIND_COMPARE: begin
                c.oor = 32'(s_word_index) >= 32'(NumWords);
                c.cmd = c.oor ? CMD_NOP : CMD_WORD;
            end
            default: c.cmd = CMD_NOP;
        endcase
    end

    assign s_ready = cnt_reg != 2'd2;
    assign q_valid = cnt_reg != 2'd0;
    assign q_cmd   = q_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) q_reg[wr_ptr_reg] <= c;
    end
endmodule

// ===== rtl/bsr_exec.sv =====
// ----------------------------------------------------------------------------
// bsr_exec - command executor
// Sequences the word memory: single reads and writes, fill, count and scan.
// ----------------------------------------------------------------------------
module bsr_exec
    import bsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  bsr_cmd_t    q_cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output bsr_res_t    m_res
);
    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_RD, ST_WB, ST_FILL, ST_CNT, ST_HI, ST_OUT
    } state_t;

    state_t      state_reg;
    bsr_cmd_t    cmd_reg;
    logic [5:0]  addr_reg;
    logic [6:0]  left_reg;      // words still to receive from the read pipe
    logic        rdv_reg;       // a read was issued last cycle
    logic [5:0]  rdaddr_reg;
    logic [11:0] acc_reg;
    logic        found_reg;
    bsr_res_t    res_reg;

    logic        we;
    logic [5:0]  addr;
    logic [31:0] wdata, rdata, nw, fillw, cmask;
    logic [11:0] wlo;

    bsr_ram #(.Width(WordBits), .Depth(NumWords)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign q_ready = state_reg == ST_IDLE;
    assign m_valid = state_reg == ST_OUT;
    assign m_res   = res_reg;

    // fill word for address
    always_comb begin
        wlo = {1'b0, addr_reg, 5'd0};
        if (cmd_reg.limit >= wlo + 12'd32) fillw = '1;
        else if (cmd_reg.limit > wlo) fillw = ~(32'hffffffff << (cmd_reg.limit - wlo));
        else fillw = '0;
    end

    // count mask for the word just read
    always_comb begin
        if ({1'b0, rdaddr_reg} < cmd_reg.limit[11:5]) cmask = '1;
        else if ({1'b0, rdaddr_reg} == cmd_reg.limit[11:5])
            cmask = ~(32'hffffffff << cmd_reg.limit[4:0]);
        else cmask = '0;
    end

    always_comb begin
        unique case (cmd_reg.merge_op)
            MOP_AND:    nw = rdata & cmd_reg.word_a;
            MOP_OR:     nw = rdata | cmd_reg.word_a;
            MOP_ANDNOT: nw = rdata & ~cmd_reg.word_a;
            MOP_ORMASK: nw = rdata | (cmd_reg.word_a & ~cmd_reg.word_b);
            MOP_REPL:   nw = cmd_reg.word_a;
            default:    nw = rdata;
        endcase
    end

    always_comb begin
        we = 1'b0;
        addr = addr_reg;
        wdata = '0;
        unique case (state_reg)
            ST_INIT: we = 1'b1;
            ST_FILL: begin
                we = 1'b1;
                wdata = fillw;
            end
            ST_WB: begin
                we = (cmd_reg.cmd == CMD_WORD) ? (cmd_reg.kind == KIND_MERGE)
                                               : (cmd_reg.kind != KIND_TEST);
                if (cmd_reg.cmd == CMD_WORD) wdata = nw;
                else if (cmd_reg.kind == KIND_SET)
                    wdata = rdata | (32'd1 << cmd_reg.limit[4:0]);
                else wdata = rdata & ~(32'd1 << cmd_reg.limit[4:0]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            addr_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_INIT: begin
                    addr_reg <= addr_reg + 6'd1;
                    if (addr_reg == 6'(NumWords - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: if (q_valid) begin
                    cmd_reg   <= q_cmd;
                    // highest search starts at minus one (empty map)
                    res_reg   <= '{bit_value: 1'b0, set_count: 12'd0,
                                   top_index: {12{q_cmd.cmd == CMD_HIGHEST}},
                                   word_changed: 1'b0, words_equal: 1'b0,
                                   out_of_range: q_cmd.oor};
                    acc_reg   <= '0;
                    found_reg <= 1'b0;
                    rdv_reg   <= 1'b0;
                    left_reg  <= 7'(NumWords);
                    unique case (q_cmd.cmd)
                        CMD_BIT: begin
                            addr_reg  <= q_cmd.limit[10:5];
                            state_reg <= ST_RD;
                        end
                        CMD_WORD: begin
                            addr_reg  <= q_cmd.word_idx;
                            state_reg <= ST_RD;
                        end
                        CMD_FILL: begin
                            addr_reg  <= '0;
                            state_reg <= ST_FILL;
                        end
                        CMD_COUNT: begin
                            addr_reg  <= '0;
                            state_reg <= ST_CNT;
                        end
                        CMD_HIGHEST: begin
                            addr_reg  <= 6'(NumWords - 1);
                            state_reg <= ST_HI;
                        end
                        default: state_reg <= ST_OUT;
                    endcase
                end
                ST_RD: state_reg <= ST_WB;
                ST_WB: begin
                    if (cmd_reg.cmd == CMD_BIT)
                        res_reg.bit_value <= (cmd_reg.kind == KIND_TEST) &&
                                             rdata[cmd_reg.limit[4:0]];
                    else if (cmd_reg.kind == KIND_MERGE)
                        res_reg.word_changed <= nw != rdata;
                    else
                        res_reg.words_equal <= rdata == cmd_reg.word_a;
                    state_reg <= ST_OUT;
                end
                ST_FILL: begin
                    addr_reg <= addr_reg + 6'd1;
                    if (addr_reg == 6'(NumWords - 1)) state_reg <= ST_OUT;
                end
                ST_CNT, ST_HI: begin
                    // pipelined scan: issue one read per cycle, fold the last one
                    rdaddr_reg <= addr_reg;
                    rdv_reg    <= left_reg != 7'd0 &&
                                  (rdv_reg || left_reg == 7'(NumWords));
                    if (left_reg == 7'(NumWords) || rdv_reg)
                        addr_reg <= (state_reg == ST_CNT) ? addr_reg + 6'd1
                                                          : addr_reg - 6'd1;
                    if (rdv_reg) begin
                        left_reg <= left_reg - 7'd1;
                        if (state_reg == ST_CNT)
                            acc_reg <= acc_reg + 12'(pop32(rdata & cmask));
                        else if (!found_reg && rdata != '0) begin
                            found_reg <= 1'b1;
                            res_reg.top_index <= {1'b0, rdaddr_reg, msb32(rdata)};
                        end
                        if (left_reg == 7'd1) begin
                            if (state_reg == ST_CNT)
                                res_reg.set_count <= acc_reg + 12'(pop32(rdata & cmask));
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT: if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/bitmap_store_with_rank_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_store_with_rank_unit - 2048-bit bitmap with rank and highest-bit
// ----------------------------------------------------------------------------
// Input channel s_*: one operation per transaction (test/set/clear a bit,
// clear all, set first N, count below, highest bit, merge or compare word).
// Output channel m_*: exactly one result transaction per input, in order.
// A front end classifies items into a two-entry queue, so up to two items
// are taken while the executor is busy or the receiver stalls.
// Steps: the executor takes a command in its idle state; bit, merge and
// compare then read and write back one word; clear all and set first N
// write every word (one word write per cycle); count and highest read
// every word (one word read per cycle from the single-port word memory,
// with registered read data); out-of-range bit, merge and compare items
// and unknown operations go straight to the result. The result is then
// offered and held until taken; only then is the next command taken.
// After reset the executor clears the word memory word by word; items
// are queued meanwhile. A stalled m_ready holds the result and blocks the
// executor only; the queue keeps filling until full.
// ----------------------------------------------------------------------------
module bitmap_store_with_rank_unit
    import bsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_kind,
    input  logic [11:0] s_bit_index,
    input  logic [5:0]  s_word_index,
    input  logic [31:0] s_word_a,
    input  logic [31:0] s_word_b,
    input  logic [2:0]  s_merge_op,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_bit_value,
    output logic [11:0] m_set_count,
    output logic signed [11:0] m_top_index,
    output logic        m_word_changed,
    output logic        m_words_equal,
    output logic        m_out_of_range
);
    logic     q_valid, q_ready;
    bsr_cmd_t q_cmd;
    bsr_res_t res;

    bsr_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_kind, .s_bit_index,
        .s_word_index, .s_word_a, .s_word_b, .s_merge_op,
        .q_valid, .q_ready, .q_cmd
    );

    bsr_exec u_exec (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_valid, .m_ready, .m_res(res)
    );

    assign m_bit_value    = res.bit_value;
    assign m_set_count    = res.set_count;
    assign m_top_index    = res.top_index;
    assign m_word_changed = res.word_changed;
    assign m_words_equal  = res.words_equal;
    assign m_out_of_range = res.out_of_range;
endmodule

// ===== rtl/bsr_checker.sv =====
// ----------------------------------------------------------------------------
// bsr_checker - port-level checks for the bitmap store
// Result channel stability, field exclusivity and result spacing.
// ----------------------------------------------------------------------------
module bsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_bit_value,
    input logic        m_word_changed,
    input logic        m_words_equal,
    input logic [11:0] m_set_count
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_set_count)) else $error("result changed");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_bit_value, m_word_changed, m_words_equal}) <= 1)
        else $error("flags overlap");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_set_count != 12'd0 |-> !m_bit_value && !m_words_equal)
        else $error("count mixed with other result");
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid) else $error("back-to-back result");
endmodule

bind bitmap_store_with_rank_unit bsr_checker u_bsr_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_bit_value, .m_word_changed,
    .m_words_equal, .m_set_count
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - bitmap store with rank and highest-bit search
// Drives random and directed bit, fill, count, highest, merge and compare
// operations with random idling on both channels; a scoreboard keeps a
// mirror bitmap and checks every result field in order.
// ----------------------------------------------------------------------------
class bitmap_scoreboard;
    logic [31:0] mirror_words [bsr_pkg::NumWords];
    bsr_pkg::bsr_res_t pending_results [$];
    int error_count;

    function new();
        foreach (mirror_words[i]) mirror_words[i] = '0;
        error_count = 0;
    endfunction

    function int ones_in(logic [31:0] v);
        int c;
        c = 0;
        for (int i = 0; i < 32; i++) c += v[i];
        return c;
    endfunction

    // Compute the expected result of one accepted operation and update the mirror.
    function void note_operation(logic [3:0] kind, logic [11:0] bidx, logic [5:0] widx,
                                 logic [31:0] wa, logic [31:0] wb, logic [2:0] mop);
        bsr_pkg::bsr_res_t r;
        int n, cnt, hi;
        logic [31:0] prev, nw, m;
        r = '0;
        case (kind)
            bsr_pkg::KIND_TEST, bsr_pkg::KIND_SET, bsr_pkg::KIND_CLEAR: begin
                if (bidx >= bsr_pkg::CapBits) begin
                    r.out_of_range = 1'b1;
                end else begin
                    m = 32'd1 << bidx[4:0];
                    if (kind == bsr_pkg::KIND_TEST)
                        r.bit_value = (mirror_words[bidx[10:5]] & m) != 0;
                    else if (kind == bsr_pkg::KIND_SET)
                        mirror_words[bidx[10:5]] |= m;
                    else
                        mirror_words[bidx[10:5]] &= ~m;
                end
            end
            bsr_pkg::KIND_CLR_ALL: foreach (mirror_words[i]) mirror_words[i] = '0;
            bsr_pkg::KIND_SET_N: begin
                n = bidx;
                if (n > bsr_pkg::CapBits) begin
                    n = bsr_pkg::CapBits;
                    r.out_of_range = 1'b1;
                end
                foreach (mirror_words[i]) begin
                    if (n >= i * 32 + 32) mirror_words[i] = '1;
                    else if (n > i * 32) mirror_words[i] = (32'd1 << (n - i * 32)) - 1;
                    else mirror_words[i] = '0;
                end
            end
            bsr_pkg::KIND_COUNT: begin
                n = bidx;
                if (n > bsr_pkg::CapBits) begin
                    n = bsr_pkg::CapBits;
                    r.out_of_range = 1'b1;
                end
                cnt = 0;
                for (int i = 0; i < n / 32; i++) cnt += ones_in(mirror_words[i]);
                if (n % 32 != 0)
                    cnt += ones_in(mirror_words[n / 32] & ~(32'hffffffff << (n % 32)));
                r.set_count = 12'(cnt);
            end
            bsr_pkg::KIND_HIGHEST: begin
                hi = -1;
                for (int i = 0; i < bsr_pkg::NumWords * 32; i++)
                    if (mirror_words[i / 32][i % 32]) hi = i;
                r.top_index = 12'(hi);
            end
            bsr_pkg::KIND_MERGE: begin
                prev = mirror_words[widx];
                case (mop)
                    bsr_pkg::MOP_AND:    nw = prev & wa;
                    bsr_pkg::MOP_OR:     nw = prev | wa;
                    bsr_pkg::MOP_ANDNOT: nw = prev & ~wa;
                    bsr_pkg::MOP_ORMASK: nw = prev | (wa & ~wb);
                    bsr_pkg::MOP_REPL:   nw = wa;
                    default:             nw = prev;
                endcase
                r.word_changed = nw != prev;
                mirror_words[widx] = nw;
            end
            bsr_pkg::KIND_COMPARE: r.words_equal = mirror_words[widx] == wa;
            default: ;
        endcase
        pending_results.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    task check_result(bsr_pkg::bsr_res_t got);
        bsr_pkg::bsr_res_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result transaction", 1, 0);
            return;
        end
        want = pending_results.pop_front();
        if (got.bit_value != want.bit_value)
            report_mismatch("bit_value", got.bit_value, want.bit_value);
        if (got.set_count != want.set_count)
            report_mismatch("set_count", got.set_count, want.set_count);
        if (got.top_index != want.top_index)
            report_mismatch("top_index", got.top_index, want.top_index);
        if (got.word_changed != want.word_changed)
            report_mismatch("word_changed", got.word_changed, want.word_changed);
        if (got.words_equal != want.words_equal)
            report_mismatch("words_equal", got.words_equal, want.words_equal);
        if (got.out_of_range != want.out_of_range)
            report_mismatch("out_of_range", got.out_of_range, want.out_of_range);
    endtask
endclass

module testbench;
    import bsr_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_kind = '0;
    logic [11:0] s_bit_index = '0;
    logic [5:0]  s_word_index = '0;
    logic [31:0] s_word_a = '0;
    logic [31:0] s_word_b = '0;
    logic [2:0]  s_merge_op = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_bit_value;
    logic [11:0] m_set_count;
    logic signed [11:0] m_top_index;
    logic        m_word_changed;
    logic        m_words_equal;
    logic        m_out_of_range;

    bitmap_scoreboard board = new();
    bit calm_phase = 1'b0;
    bit stimulus_done = 1'b0;

    bitmap_store_with_rank_unit DUT (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Sample both handshakes at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            board.note_operation(s_kind, s_bit_index, s_word_index, s_word_a, s_word_b,
                                 s_merge_op);
        if (aresetn && m_valid && m_ready)
            board.check_result({m_bit_value, m_set_count, m_top_index, m_word_changed,
                                m_words_equal, m_out_of_range});
    end

    // Receiver: random stall bursts, none in the calm phase.
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (!calm_phase && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 12);
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_op(logic [3:0] kind, logic [11:0] bidx, logic [5:0] widx,
                           logic [31:0] wa, logic [31:0] wb, logic [2:0] mop);
        int gap;
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_bit_index <= bidx;
        s_word_index <= widx;
        s_word_a <= wa;
        s_word_b <= wb;
        s_merge_op <= mop;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random_op();
        logic [3:0] kind;
        logic [11:0] bidx;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) kind = 4'($urandom_range(KIND_TEST, KIND_CLEAR));
        else if (pick < 52) kind = KIND_CLR_ALL;
        else if (pick < 55) kind = KIND_SET_N;
        else if (pick < 62) kind = KIND_COUNT;
        else if (pick < 67) kind = KIND_HIGHEST;
        else if (pick < 85) kind = KIND_MERGE;
        else if (pick < 96) kind = KIND_COMPARE;
        else kind = 4'($urandom_range(9, 15));
        pick = $urandom_range(0, 19);
        if (pick == 0) bidx = 12'($urandom);
        else if (pick == 1) bidx = 12'($urandom_range(CapBits - 2, CapBits + 1));
        else bidx = 12'($urandom_range(0, CapBits - 1));
        send_op(kind, bidx, 6'($urandom), $urandom,
                ($urandom_range(0, 1) ? $urandom : 32'h0), 3'($urandom_range(0, 7)));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.pending_results.size() != 0) @(negedge aclk);
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // Directed: field extremes, every operation and the special cases.
        send_op(KIND_HIGHEST, 12'd0, 6'd0, '0, '0, MOP_AND);        // empty map
        send_op(KIND_SET, 12'd0, 6'd0, '0, '0, MOP_AND);
        send_op(KIND_SET, 12'd2047, 6'd0, '0, '0, MOP_AND);
        send_op(KIND_SET, 12'd2048, 6'd0, '0, '0, MOP_AND);         // past capacity
        send_op(KIND_TEST, 12'd4095, 6'd0, '0, '0, MOP_AND);
        send_op(KIND_TEST, 12'd2047, 6'd0, '0, '0, MOP_AND);
        send_op(KIND_HIGHEST, 12'd0, 6'd0, '0, '0, MOP_AND);
        send_op(KIND_COUNT, 12'd4095, 6'd0, '0, '0, MOP_AND);       // saturated end
        send_op(KIND_CLEAR, 12'd2047, 6'd0, '0, '0, MOP_AND);
        send_op(KIND_CLEAR, 12'd3000, 6'd0, '0, '0, MOP_AND);
        send_op(KIND_SET_N, 12'd37, 6'd0, '0, '0, MOP_AND);
        send_op(KIND_COUNT, 12'd33, 6'd0, '0, '0, MOP_AND);
        send_op(KIND_COUNT, 12'd0, 6'd0, '0, '0, MOP_AND);
        send_op(KIND_SET_N, 12'd4095, 6'd0, '0, '0, MOP_AND);       // saturated fill
        send_op(KIND_COUNT, 12'd2048, 6'd0, '0, '0, MOP_AND);
        send_op(KIND_MERGE, 12'd0, 6'd63, 32'h0f0f0f0f, '0, MOP_AND);
        send_op(KIND_MERGE, 12'd0, 6'd63, 32'hffffffff, '0, MOP_OR);
        send_op(KIND_MERGE, 12'd0, 6'd1, 32'h80000001, '0, MOP_ANDNOT);
        send_op(KIND_MERGE, 12'd0, 6'd1, 32'hffffffff, 32'h7ffffffe, MOP_ORMASK);
        send_op(KIND_MERGE, 12'd0, 6'd2, 32'h12345678, '0, MOP_REPL);
        send_op(KIND_MERGE, 12'd0, 6'd2, '0, '0, 3'd7);              // undefined selector
        send_op(KIND_COMPARE, 12'd0, 6'd2, 32'h12345678, '0, MOP_AND);
        send_op(KIND_SET_N, 12'd0, 6'd0, '0, '0, MOP_AND);          // N zero clears all
        send_op(KIND_CLR_ALL, 12'd0, 6'd0, '0, '0, MOP_AND);
        send_op(4'd15, 12'hfff, 6'h3f, '1, '1, 3'd7);
        drain_results();
        for (int i = 0; i < 1150; i++) begin
            if (i == 500) drain_results();
            if (i == 1000) calm_phase = 1'b1;
            send_random_op();
        end
        s_valid <= 1'b0;
        while (board.pending_results.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (board.error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
